FILE: rtl/bdeq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_pkg
// shared sizes, request codes and ring access types for the bounded deque
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int DEPTH   = 1024;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CAP_W   = 11;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_QUERY      = 3'd4
    } func_t;

    // register index as decoded from the word address
    localparam logic REG_CAPACITY = 1'b0;

    // one cycle of ring traffic: one write, two reads
    typedef struct packed {
        logic                     wr_en;
        logic [PTR_W-1:0]         wr_addr;
        logic signed [WORD_W-1:0] wr_data;
        logic [PTR_W-1:0]         rd_addr_front;
        logic [PTR_W-1:0]         rd_addr_rear;
    } ring_req_t;

    // flags of the beat on its way to the result ports
    typedef struct packed {
        logic valid;
        logic accepted;
        logic empty;
        logic full;
    } result_flags_t;

    // fold a position below twice the depth back into the ring
    function automatic logic [PTR_W-1:0] wrap_pos(input logic [SUM_W-1:0] pos);
        logic [SUM_W-1:0] folded;
        folded = (pos >= SUM_W'(DEPTH)) ? pos - SUM_W'(DEPTH) : pos;
        return folded[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bdeq_apb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_apb
// configuration register port, holds the capacity register
// ----------------------------------------------------------------------------
module bdeq_apb
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bdeq_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [bdeq_pkg::PDATA_W-1:0]     pwdata,
    output logic      [bdeq_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready,
    output logic      [bdeq_pkg::CAP_W-1:0]       capacity
);

    logic [bdeq_pkg::CAP_W-1:0] capacity_reg;
    logic [bdeq_pkg::CAP_W-1:0] capacity_next;
    logic                       reg_index;
    logic                       wr_strobe;

    assign reg_index = paddr[bdeq_pkg::PADDR_W-1];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_strobe && (reg_index == bdeq_pkg::REG_CAPACITY))
        begin
            capacity_next = pwdata[bdeq_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            bdeq_pkg::REG_CAPACITY:
            begin
                prdata = bdeq_pkg::PDATA_W'(capacity_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bdeq_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign capacity = capacity_reg;

endmodule

`default_nettype wire

FILE: rtl/bdeq_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_ring
// ring store, one write and two registered reads per cycle
// ----------------------------------------------------------------------------
module bdeq_ring
(
    input  wire logic                                 clk,
    input  wire bdeq_pkg::ring_req_t                  req,
    output logic signed [bdeq_pkg::WORD_W-1:0]        front_data,
    output logic signed [bdeq_pkg::WORD_W-1:0]        rear_data
);

    logic signed [bdeq_pkg::WORD_W-1:0] mem [bdeq_pkg::DEPTH];

    logic signed [bdeq_pkg::WORD_W-1:0] rd_front_reg;
    logic signed [bdeq_pkg::WORD_W-1:0] rd_rear_reg;
    logic signed [bdeq_pkg::WORD_W-1:0] byp_data_reg;
    logic                               byp_front_reg;
    logic                               byp_rear_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_front_reg  <= mem[req.rd_addr_front];
        rd_rear_reg   <= mem[req.rd_addr_rear];
        // a read of the word written on the same edge sees the new data through the bypass
        byp_data_reg  <= req.wr_data;
        byp_front_reg <= req.wr_en && (req.wr_addr == req.rd_addr_front);
        byp_rear_reg  <= req.wr_en && (req.wr_addr == req.rd_addr_rear);
    end

    assign front_data = byp_front_reg ? byp_data_reg : rd_front_reg;
    assign rear_data  = byp_rear_reg  ? byp_data_reg : rd_rear_reg;

endmodule

`default_nettype wire

FILE: rtl/bdeq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_ctrl
// head and count update, ring addressing and result flags
// ----------------------------------------------------------------------------
module bdeq_ctrl
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 take,
    input  wire logic        [bdeq_pkg::FUNC_W-1:0]   func,
    input  wire logic signed [bdeq_pkg::WORD_W-1:0]   push_value,
    input  wire logic        [bdeq_pkg::CAP_W-1:0]    capacity,
    output bdeq_pkg::ring_req_t                       req,
    output bdeq_pkg::result_flags_t                   flags
);

    logic [bdeq_pkg::PTR_W-1:0] head_reg;
    logic [bdeq_pkg::PTR_W-1:0] head_next;
    logic [bdeq_pkg::CNT_W-1:0] count_reg;
    logic [bdeq_pkg::CNT_W-1:0] count_next;
    bdeq_pkg::result_flags_t    flags_reg;
    bdeq_pkg::result_flags_t    flags_next;

    logic [bdeq_pkg::CMP_W-1:0] cap_wide;
    logic [bdeq_pkg::CMP_W-1:0] eff_cap;
    logic                       is_full;
    logic                       is_empty;
    logic                       ok;
    logic [bdeq_pkg::SUM_W-1:0] rear_sum;
    logic [bdeq_pkg::PTR_W-1:0] tail_pos;
    bdeq_pkg::func_t            code;

    assign code     = bdeq_pkg::func_t'(func);
    assign cap_wide = bdeq_pkg::CMP_W'(capacity);
    assign eff_cap  = (cap_wide > bdeq_pkg::CMP_W'(bdeq_pkg::DEPTH))
                      ? bdeq_pkg::CMP_W'(bdeq_pkg::DEPTH) : cap_wide;
    assign is_full  = bdeq_pkg::CMP_W'(count_reg) >= eff_cap;
    assign is_empty = (count_reg == '0);
    // first free slot behind the rear
    assign tail_pos = bdeq_pkg::wrap_pos(bdeq_pkg::SUM_W'(head_reg)
                                         + bdeq_pkg::SUM_W'(count_reg));

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        ok          = 1'b1;
        req.wr_en   = 1'b0;
        req.wr_addr = tail_pos;
        req.wr_data = push_value;
        if (take)
        begin
            unique case (code)
                bdeq_pkg::FN_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        head_next   = (head_reg == '0)
                                      ? bdeq_pkg::PTR_W'(bdeq_pkg::DEPTH - 1)
                                      : head_reg - 1'b1;
                        req.wr_en   = 1'b1;
                        req.wr_addr = head_next;
                        count_next  = count_reg + 1'b1;
                    end
                end
                bdeq_pkg::FN_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        req.wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                bdeq_pkg::FN_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        head_next  = bdeq_pkg::wrap_pos(bdeq_pkg::SUM_W'(head_reg)
                                                        + 1'b1);
                        count_next = count_reg - 1'b1;
                    end
                end
                bdeq_pkg::FN_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    ok = 1'b1;
                end
            endcase
        end
        // ring reads address the front and rear as they stand after the step
        rear_sum          = bdeq_pkg::SUM_W'(head_next) + bdeq_pkg::SUM_W'(count_next)
                            - 1'b1;
        req.rd_addr_front = head_next;
        req.rd_addr_rear  = (count_next == '0) ? head_next
                            : bdeq_pkg::wrap_pos(rear_sum);
    end

    always_comb
    begin
        flags_next.valid    = take;
        flags_next.accepted = ok;
        flags_next.empty    = (count_next == '0);
        flags_next.full     = bdeq_pkg::CMP_W'(count_next) >= eff_cap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

FILE: rtl/bounded_double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// bounded deque of signed 32-bit words held in a ring store
// ----------------------------------------------------------------------------
// A command is taken on every clock edge with start high; busy never rises,
// so one command per cycle is sustained. Each command gives exactly one
// result beat, with done high, in the cycle right after the start cycle;
// the beat is on the result ports for that one cycle only and the receiver
// cannot hold it off, so it must be captured there. The result is
// registered because the ring memory's reads of the new front and rear words
// are registered alongside the result flags. A push is refused when the entry
// count has reached the capacity (capped at the ring depth, a capacity of
// zero refuses every push); a pop is refused on an empty deque. When empty,
// the front and rear words read as all ones. The capacity register sits at
// byte address 0 of the configuration port and is only to be written while
// no command is in flight. No clearing pass follows reset: only pushed
// entries are read.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [bdeq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [bdeq_pkg::PDATA_W-1:0]  pwdata,
    output logic             [bdeq_pkg::PDATA_W-1:0]  prdata,
    output logic                                      pready,
    // command side
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [bdeq_pkg::FUNC_W-1:0]   func,
    input  wire logic signed [bdeq_pkg::WORD_W-1:0]   push_value,
    // result side
    output logic                                      done,
    output logic                                      accepted,
    output logic signed      [bdeq_pkg::WORD_W-1:0]   front_word,
    output logic signed      [bdeq_pkg::WORD_W-1:0]   rear_word,
    output logic                                      now_empty,
    output logic                                      now_full
);

    logic [bdeq_pkg::CAP_W-1:0]         capacity;
    logic                               take;
    bdeq_pkg::ring_req_t                req;
    bdeq_pkg::result_flags_t            flags;
    logic signed [bdeq_pkg::WORD_W-1:0] front_data;
    logic signed [bdeq_pkg::WORD_W-1:0] rear_data;

    // every operation touches only head, count and at most one ring slot
    assign busy = 1'b0;
    assign take = start && !busy;

    // capacity register
    bdeq_apb u_apb
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // pointer update on the command beat, drives ring write and reads
    bdeq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .func       (func),
        .push_value (push_value),
        .capacity   (capacity),
        .req        (req),
        .flags      (flags)
    );

    // ring store, read data lines up with the registered flags
    bdeq_ring u_ring
    (
        .clk        (clk),
        .req        (req),
        .front_data (front_data),
        .rear_data  (rear_data)
    );

    // result beat: empty deque reports all ones in both words
    assign done       = flags.valid;
    assign accepted   = flags.accepted;
    assign now_empty  = flags.empty;
    assign now_full   = flags.full;
    assign front_word = flags.empty ? bdeq_pkg::EMPTY_WORD : front_data;
    assign rear_word  = flags.empty ? bdeq_pkg::EMPTY_WORD : rear_data;

endmodule

`default_nettype wire

FILE: dv/deque_checker.sv
// ----------------------------------------------------------------------------
// deque_checker
// watches the command, result and register ports of the bounded deque, keeps
// its own ring, head and count, and compares every result beat with the
// oldest predicted beat
// ----------------------------------------------------------------------------
module deque_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [bdeq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [bdeq_pkg::PDATA_W-1:0]  pwdata,
    input  wire logic                                 pready,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic        [bdeq_pkg::FUNC_W-1:0]   func,
    input  wire logic signed [bdeq_pkg::WORD_W-1:0]   push_value,
    input  wire logic                                 done,
    input  wire logic                                 accepted,
    input  wire logic signed [bdeq_pkg::WORD_W-1:0]   front_word,
    input  wire logic signed [bdeq_pkg::WORD_W-1:0]   rear_word,
    input  wire logic                                 now_empty,
    input  wire logic                                 now_full,
    output int unsigned                               fail_count,
    output int unsigned                               pending
);
    import bdeq_pkg::*;

    localparam int unsigned PRINT_LIMIT = 30;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] rear;
        logic                     empty;
        logic                     full;
    } deq_view_t;

    logic signed [WORD_W-1:0] ring_copy [DEPTH];
    int unsigned              head_at;
    int unsigned              live_count;
    logic [CAP_W-1:0]         cap_copy;
    deq_view_t                awaited_views[$];
    deq_view_t                want;
    int unsigned              beats_seen;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] result beat %0d: %s", $realtime, beats_seen, msg);
        fail_count++;
    endtask

    // one request against the local copy, returns the view after the step
    function automatic deq_view_t apply_request(input logic [FUNC_W-1:0] fn,
                                                input logic signed [WORD_W-1:0] word);
        deq_view_t   v;
        int unsigned limit;
        limit = (cap_copy > DEPTH) ? DEPTH : cap_copy;
        v.ok  = 1'b1;
        case (fn)
            FN_PUSH_FRONT:
                if (live_count >= limit)
                    v.ok = 1'b0;
                else
                begin
                    head_at = (head_at + DEPTH - 1) % DEPTH;
                    ring_copy[head_at] = word;
                    live_count++;
                end
            FN_PUSH_REAR:
                if (live_count >= limit)
                    v.ok = 1'b0;
                else
                begin
                    ring_copy[(head_at + live_count) % DEPTH] = word;
                    live_count++;
                end
            FN_POP_FRONT:
                if (live_count == 0)
                    v.ok = 1'b0;
                else
                begin
                    head_at = (head_at + 1) % DEPTH;
                    live_count--;
                end
            FN_POP_REAR:
                if (live_count == 0)
                    v.ok = 1'b0;
                else
                    live_count--;
            default: ;
        endcase
        if (live_count == 0)
        begin
            v.front = EMPTY_WORD;
            v.rear  = EMPTY_WORD;
            v.empty = 1'b1;
        end
        else
        begin
            v.front = ring_copy[head_at];
            v.rear  = ring_copy[(head_at + live_count - 1) % DEPTH];
            v.empty = 1'b0;
        end
        v.full = (live_count >= limit);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_at    = 0;
            live_count = 0;
            cap_copy   = CAP_RESET;
            beats_seen = 0;
            awaited_views.delete();
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_CAPACITY)
                cap_copy = pwdata[CAP_W-1:0];
            if (start && !busy)
                awaited_views.push_back(apply_request(func, push_value));
            if (done)
            begin
                if (awaited_views.size() == 0)
                    report_mismatch("beat arrived with no command waiting");
                else
                begin
                    want = awaited_views.pop_front();
                    if (accepted !== want.ok)
                        report_mismatch($sformatf("accepted %0b, expected %0b",
                                                  accepted, want.ok));
                    if (front_word !== want.front)
                        report_mismatch($sformatf("front_word %0d, expected %0d",
                                                  front_word, want.front));
                    if (rear_word !== want.rear)
                        report_mismatch($sformatf("rear_word %0d, expected %0d",
                                                  rear_word, want.rear));
                    if (now_empty !== want.empty)
                        report_mismatch($sformatf("now_empty %0b, expected %0b",
                                                  now_empty, want.empty));
                    if (now_full !== want.full)
                        report_mismatch($sformatf("now_full %0b, expected %0b",
                                                  now_full, want.full));
                end
                beats_seen++;
            end
            pending <= awaited_views.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives commands and capacity writes into the bounded deque and gives the
// verdict; all prediction and comparison lives in deque_checker
// ----------------------------------------------------------------------------
module testbench;
    import bdeq_pkg::*;

    // sender idle rates, percent of cycles the sender sits idle
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 49;
    localparam int IDLE_LIGHT = 21;
    // cycles with no command or result beat before the run is called hung
    localparam int QUIET_LIMIT = 1000;

    logic                     clk;
    logic                     rst_n      = 1'b0;
    logic                     psel       = 1'b0;
    logic                     penable    = 1'b0;
    logic                     pwrite     = 1'b0;
    logic [PADDR_W-1:0]       paddr      = '0;
    logic [PDATA_W-1:0]       pwdata     = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     start      = 1'b0;
    logic                     busy;
    logic [FUNC_W-1:0]        func       = FN_QUERY;
    logic signed [WORD_W-1:0] push_value = '0;
    logic                     done;
    logic                     accepted;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     now_empty;
    logic                     now_full;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned quiet_cycles = 0;
    int          idle_pct     = IDLE_NONE;
    int          sent         = 0;
    int          settings     = 0;

    bounded_double_ended_queue dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .push_value (push_value),
        .done       (done),
        .accepted   (accepted),
        .front_word (front_word),
        .rear_word  (rear_word),
        .now_empty  (now_empty),
        .now_full   (now_full)
    );

    deque_checker u_deque_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .push_value (push_value),
        .done       (done),
        .accepted   (accepted),
        .front_word (front_word),
        .rear_word  (rear_word),
        .now_empty  (now_empty),
        .now_full   (now_full),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hang detection: any command or result beat counts as progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no progress for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // setup then access cycle; the register takes the value on the access edge
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_CAPACITY, 2'b00});
        pwdata  <= PDATA_W'(cap);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    // one command beat; each cycle in front of it idles with chance idle_pct
    task automatic issue_command(input logic [FUNC_W-1:0] fn,
                                 input logic signed [WORD_W-1:0] word);
        while (idle_pct != IDLE_NONE && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        func       <= fn;
        push_value <= word;
        // taken on the first edge with busy low
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // stop sending and wait until every predicted beat has been seen;
    // pending is registered, so the loop always takes at least one step
    task automatic settle_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // ring read latency, keeps the register write clear of the pipe
        repeat (2) @(posedge clk);
    endtask

    // new capacity, then random commands with a push share of push_pct
    task automatic run_phase(input int cap, input int n_items, input int push_pct,
                             input int idle);
        int                       roll;
        logic [FUNC_W-1:0]        fn;
        logic signed [WORD_W-1:0] word;
        settle_idle();
        write_capacity(CAP_W'(cap));
        idle_pct = idle;
        repeat (n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                fn = $urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
            else if (roll < 96)
                fn = $urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT;
            else if (roll < 98)
                fn = FN_QUERY;
            else
                fn = FUNC_W'($urandom_range(FN_QUERY + 1, 2 ** FUNC_W - 1));
            // mostly random words, now and then an extreme one
            case ($urandom_range(0, 11))
                0:       word = 32'sh8000_0000;
                1:       word = 32'sh7fff_ffff;
                2:       word = '0;
                3:       word = '1;
                default: word = $urandom();
            endcase
            issue_command(fn, word);
        end
    endtask

    initial
    begin
        int guard;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset capacity
        // pops on an empty deque are refused, query reports all ones
        issue_command(FN_POP_FRONT, 32'sd5);
        issue_command(FN_POP_REAR, '1);
        issue_command(FN_QUERY, 32'sh1234_5678);
        // spare codes behave as a query
        for (int c = FN_QUERY + 1; c < 2 ** FUNC_W; c++)
            issue_command(FUNC_W'(c), $urandom());
        // front push from head zero wraps to the top of the ring
        issue_command(FN_PUSH_FRONT, 32'sh7fff_ffff);
        issue_command(FN_PUSH_REAR, 32'sh8000_0000);
        // a live all-ones word must not look like an empty deque
        issue_command(FN_PUSH_FRONT, '1);
        issue_command(FN_PUSH_REAR, '0);
        issue_command(FN_QUERY, '1);
        issue_command(FN_POP_REAR, 32'sd77);
        issue_command(FN_POP_FRONT, '0);
        issue_command(FN_POP_FRONT, '1);
        issue_command(FN_POP_REAR, 32'sh8000_0000);
        // empty again, both pops refused
        issue_command(FN_POP_REAR, 32'sh7fff_ffff);
        issue_command(FN_POP_FRONT, '0);

        // capacity of one, then zero: empty and full at once, every push refused
        run_phase(1, 30, 60, IDLE_NONE);
        run_phase(0, 20, 60, IDLE_HEAVY);
        // fill a small deque, then drop the capacity below the count
        run_phase(8, 14, 95, IDLE_LIGHT);
        run_phase(2, 40, 40, IDLE_NONE);
        run_phase(5, 80, 55, IDLE_HEAVY);
        run_phase(16, 90, 55, IDLE_LIGHT);
        run_phase(3, 60, 50, IDLE_NONE);
        // top code saturates to the ring size, pushes keep going through
        run_phase(2 ** CAP_W - 1, 60, 95, IDLE_HEAVY);
        run_phase(DEPTH, 40, 30, IDLE_LIGHT);

        // drain, then let the last beat clear the pipe
        start <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending != 0 && guard < 64);
        repeat (4) @(posedge clk);

        $display("%0d commands sent over %0d capacity writes and the reset setting",
                 sent, settings);
        $display("capacities from zero to the top code, ring wrap and shrink below count");
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/bdeq_pkg.sv
rtl/bdeq_apb.sv
rtl/bdeq_ring.sv
rtl/bdeq_ctrl.sv
rtl/bounded_double_ended_queue.sv
dv/deque_checker.sv
dv/testbench.sv
